FILE: src/tpf_pkg.sv
`default_nettype none
package tpf_pkg;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_SPRITE = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    STEP_BG_TILE   = 3'd0,
    STEP_BG_LOW    = 3'd1,
    STEP_BG_HIGH   = 3'd2,
    STEP_BG_PUSH   = 3'd3,
    STEP_SP_TILE   = 3'd4,
    STEP_SP_LOW    = 3'd5,
    STEP_SP_HIGH   = 3'd6,
    STEP_SP_PUSH   = 3'd7
  } step_t;

  localparam logic [1:0] TGT_NONE   = 2'd0;
  localparam logic [1:0] TGT_BG     = 2'd1;
  localparam logic [1:0] TGT_SPRITE = 2'd2;

  localparam logic [2:0] REG_LCDC = 3'd0;
  localparam logic [2:0] REG_SCX  = 3'd1;
  localparam logic [2:0] REG_SCY  = 3'd2;
  localparam logic [2:0] REG_WX   = 3'd3;
  localparam logic [2:0] REG_WY   = 3'd4;

  localparam logic [12:0] MAP_LOW_OFS  = 13'h1800;
  localparam logic [12:0] MAP_HIGH_OFS = 13'h1C00;
  localparam logic [12:0] SIGNED_BASE  = 13'h1000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  line;
    logic        bg_fifo_empty;
    logic [3:0]  sprite_fifo_count;
    logic [12:0] mem_address;
    logic [7:0]  mem_data;
    logic [7:0]  sprite_tile;
    logic [7:0]  sprite_row;
    logic [7:0]  sprite_col;
    logic [7:0]  sprite_attr;
  } in_item_t;

  typedef struct packed {
    logic [1:0] push_target;
    logic [1:0] pixel_color;
    logic [1:0] palette_select;
    logic       behind_background;
    logic       fifo_stopped;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [7:0] lcdc;
    logic [7:0] scx;
    logic [7:0] scy;
    logic [7:0] wx;
    logic [7:0] wy;
  } cfg_regs_t;

  // One burst of results for one item; colors packed in push order.
  typedef struct packed {
    logic [2:0]  cnt_m1;
    logic [1:0]  target;
    logic [15:0] colors;
    logic [1:0]  pal;
    logic        beh;
    logic        stopped;
  } burst_t;

endpackage
`default_nettype wire

FILE: src/tile_pixel_fetcher.sv
`default_nettype none
// Tile pixel fetcher with an 8 KiB video memory inside. Every input item
// (tick, memory write, sprite start, fetcher reset) is taken in one cycle,
// back to back, while the queue ahead of the output has room; a memory
// read issued by a tick lands in its register on the next cycle, so the
// following tick already sees it. Each item yields one result, or eight
// background pixels, or one to eight sprite pixels; the output side emits
// one result per unstalled cycle, so a pixel push holds it for one result
// per pixel, which a four-deep burst queue absorbs. No clearing pass.
module tile_pixel_fetcher
  import tpf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_item,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_item,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  cfg_regs_t cfg_r;
  logic      take, full, empty, pop;
  burst_t    burst, head;

  assign pready   = 1'b1;
  assign in_stall = full;
  assign take     = in_valid && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        REG_LCDC: cfg_r.lcdc <= pwdata[7:0];
        REG_SCX:  cfg_r.scx  <= pwdata[7:0];
        REG_SCY:  cfg_r.scy  <= pwdata[7:0];
        REG_WX:   cfg_r.wx   <= pwdata[7:0];
        REG_WY:   cfg_r.wy   <= pwdata[7:0];
        default:  cfg_r      <= cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_LCDC: prdata = {24'd0, cfg_r.lcdc};
      REG_SCX:  prdata = {24'd0, cfg_r.scx};
      REG_SCY:  prdata = {24'd0, cfg_r.scy};
      REG_WX:   prdata = {24'd0, cfg_r.wx};
      REG_WY:   prdata = {24'd0, cfg_r.wy};
      default:  prdata = '0;
    endcase
  end

  tpf_front u_front (
    .clk  (clk),
    .rst_n(rst_n),
    .take (take),
    .item (in_item),
    .cfg  (cfg_r),
    .burst(burst)
  );

  tpf_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (take),
    .wdata(burst),
    .pop  (pop),
    .full (full),
    .empty(empty),
    .head (head)
  );

  tpf_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .have     (!empty),
    .head     (head),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_item (out_item),
    .pop      (pop)
  );
endmodule
`default_nettype wire

FILE: src/tpf_ram.sv
`default_nettype none
module tpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

FILE: src/tpf_front.sv
`default_nettype none
module tpf_front
  import tpf_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      take,
  input  wire in_item_t  item,
  input  wire cfg_regs_t cfg,
  output burst_t         burst
);
  step_t       step_r, step_nxt;
  logic [7:0]  tcol_r, tcol_nxt;
  logic        win_r, win_nxt;
  logic [7:0]  tile_r, tile_nxt, plow_r, plow_nxt, phigh_r, phigh_nxt;
  logic [31:0] spr_r, spr_nxt;
  logic        stop_r, stop_nxt;
  // a memory load lands in the read register in the cycle after it is issued
  logic        pend_tile_r, pend_low_r, pend_high_r;
  logic        ld_tile, ld_low, ld_high;

  logic [7:0]  rdata, tile_e, plow_e, phigh_e;
  logic        re, we;
  logic [12:0] raddr;

  logic        win_now;
  logic [4:0]  map_x, map_y;
  logic [4:0]  wq;
  logic [12:0] map_addr;
  logic [12:0] bg_base, bg_row;
  logic [8:0]  wd, wmag;
  logic [7:0]  woff, r2;
  logic [2:0]  srow;
  logic [12:0] sp_row;
  logic [7:0]  attr, scol;
  logic [3:0]  sstart, smin;
  logic [15:0] scolors, bcolors;
  logic [2:0]  j;

  tpf_ram #(.WIDTH(8), .DEPTH(8192)) u_vram (
    .clk  (clk),
    .we   (we),
    .waddr(item.mem_address),
    .wdata(item.mem_data),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign tile_e  = pend_tile_r ? rdata : tile_r;
  assign plow_e  = pend_low_r  ? rdata : plow_r;
  assign phigh_e = pend_high_r ? rdata : phigh_r;
  assign attr    = spr_r[31:24];
  assign scol    = spr_r[23:16];

  // tile map address
  always_comb begin
    win_now = cfg.lcdc[5] && (cfg.wy <= item.line) && (cfg.wx <= tcol_r);
    wq      = (cfg.wx >= 8'd7) ? 5'((cfg.wx - 8'd7) >> 3) : 5'd0;
    if (win_now) begin
      map_x    = tcol_r[4:0] - wq;
      map_y    = item.line[4:0] - 5'(cfg.wy >> 3);
      map_addr = cfg.lcdc[6] ? MAP_HIGH_OFS : MAP_LOW_OFS;
    end else begin
      map_x    = 5'(cfg.scx >> 3) + tcol_r[4:0];
      map_y    = 5'((item.line + cfg.scy) >> 3);
      map_addr = cfg.lcdc[3] ? MAP_HIGH_OFS : MAP_LOW_OFS;
    end
    map_addr = map_addr + {8'd0, map_x} + {3'd0, map_y, 5'd0};
  end

  // background tile row address
  always_comb begin
    if (cfg.lcdc[4]) begin
      bg_base = {1'b0, tile_e, 4'd0};
    end else begin
      bg_base = SIGNED_BASE + {tile_e[7], tile_e, 4'd0};
    end
    wd   = {1'b0, item.line} - {1'b0, cfg.wy};
    wmag = wd[8] ? (~wd + 9'd1) : wd;
    r2   = {4'd0, wmag[2:0], 1'b0};
    woff = wd[8] ? (8'd0 - r2) : r2;
    if (win_r) begin
      bg_row = bg_base + {5'd0, woff};
    end else begin
      bg_row = bg_base + {9'd0, 3'(item.line + cfg.scy), 1'b0};
    end
  end

  // sprite row address and pixel selection
  always_comb begin
    srow = 3'(item.line + spr_r[15:8]);
    if (attr[5]) begin
      srow = 3'd7 - srow;
    end
    sp_row = {1'b0, tile_e, 4'd0} + {9'd0, srow, 1'b0};
    for (int i = 0; i < 8; i++) begin
      j = attr[6] ? 3'(i) : 3'(7 - i);
      scolors[2*i +: 2] = {phigh_e[j], plow_e[j]};
      bcolors[2*i +: 2] = {phigh_e[7-i], plow_e[7-i]};
    end
    smin   = (scol >= 8'd8) ? 4'd0 : 4'(8'd8 - scol);
    sstart = (item.sprite_fifo_count > smin) ? item.sprite_fifo_count : smin;
  end

  always_comb begin
    step_nxt  = step_r;
    tcol_nxt  = tcol_r;
    win_nxt   = win_r;
    tile_nxt  = tile_e;
    plow_nxt  = plow_e;
    phigh_nxt = phigh_e;
    spr_nxt   = spr_r;
    stop_nxt  = stop_r;
    ld_tile   = 1'b0;
    ld_low    = 1'b0;
    ld_high   = 1'b0;
    re        = 1'b0;
    we        = 1'b0;
    raddr     = map_addr;
    burst     = '0;
    if (take) begin
      unique case (kind_t'(item.kind))
        KIND_WRITE: we = 1'b1;
        KIND_SPRITE: begin
          spr_nxt  = {item.sprite_attr, item.sprite_col, item.sprite_row, item.sprite_tile};
          step_nxt = STEP_SP_TILE;
          stop_nxt = 1'b1;
        end
        KIND_CLEAR: begin
          step_nxt  = STEP_BG_TILE;
          tcol_nxt  = '0;
          win_nxt   = 1'b0;
          tile_nxt  = '0;
          plow_nxt  = '0;
          phigh_nxt = '0;
          spr_nxt   = '0;
          stop_nxt  = 1'b0;
        end
        KIND_TICK: begin
          unique case (step_r)
            STEP_BG_TILE: begin
              win_nxt  = win_now;
              re       = 1'b1;
              ld_tile  = 1'b1;
              step_nxt = STEP_BG_LOW;
            end
            STEP_BG_LOW: begin
              re       = 1'b1;
              raddr    = bg_row;
              ld_low   = 1'b1;
              step_nxt = STEP_BG_HIGH;
            end
            STEP_BG_HIGH: begin
              re       = 1'b1;
              raddr    = bg_row + 13'd1;
              ld_high  = 1'b1;
              step_nxt = STEP_BG_PUSH;
            end
            STEP_BG_PUSH: begin
              if (item.bg_fifo_empty) begin
                burst.cnt_m1 = 3'd7;
                burst.target = TGT_BG;
                burst.colors = bcolors;
                tcol_nxt     = tcol_r + 8'd1;
                step_nxt     = STEP_BG_TILE;
              end
            end
            STEP_SP_TILE: begin
              tile_nxt = spr_r[7:0];
              step_nxt = STEP_SP_LOW;
            end
            STEP_SP_LOW: begin
              re       = 1'b1;
              raddr    = sp_row;
              ld_low   = 1'b1;
              step_nxt = STEP_SP_HIGH;
            end
            STEP_SP_HIGH: begin
              re       = 1'b1;
              raddr    = sp_row + 13'd1;
              ld_high  = 1'b1;
              step_nxt = STEP_SP_PUSH;
            end
            STEP_SP_PUSH: begin
              if (sstart < 4'd8) begin
                burst.cnt_m1 = 3'd7 - sstart[2:0];
                burst.target = TGT_SPRITE;
                burst.colors = scolors >> {sstart[2:0], 1'b0};
                burst.pal    = attr[4] ? 2'd2 : 2'd1;
                burst.beh    = attr[7];
              end
              stop_nxt = 1'b0;
              step_nxt = STEP_BG_TILE;
            end
            default: step_nxt = STEP_BG_TILE;
          endcase
        end
        default: step_nxt = step_r;
      endcase
    end
    burst.stopped = stop_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= STEP_BG_TILE;
      tcol_r      <= '0;
      win_r       <= 1'b0;
      tile_r      <= '0;
      plow_r      <= '0;
      phigh_r     <= '0;
      spr_r       <= '0;
      stop_r      <= 1'b0;
      pend_tile_r <= 1'b0;
      pend_low_r  <= 1'b0;
      pend_high_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      tcol_r      <= tcol_nxt;
      win_r       <= win_nxt;
      tile_r      <= tile_nxt;
      plow_r      <= plow_nxt;
      phigh_r     <= phigh_nxt;
      spr_r       <= spr_nxt;
      stop_r      <= stop_nxt;
      pend_tile_r <= ld_tile;
      pend_low_r  <= ld_low;
      pend_high_r <= ld_high;
    end
  end
endmodule
`default_nettype wire

FILE: src/tpf_queue.sv
`default_nettype none
module tpf_queue
  import tpf_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire burst_t wdata,
  input  wire logic   pop,
  output logic        full,
  output logic        empty,
  output burst_t      head
);
  burst_t     slot_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  assign full  = (cnt_r == 3'd4);
  assign empty = (cnt_r == 3'd0);
  assign head  = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 2'd1;
      end
      if (pop) begin
        rp_r <= rp_r + 2'd1;
      end
      cnt_r <= cnt_r + {2'd0, push} - {2'd0, pop};
    end
  end
endmodule
`default_nettype wire

FILE: src/tpf_back.sv
`default_nettype none
module tpf_back
  import tpf_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   have,
  input  wire burst_t head,
  input  wire logic   out_stall,
  output logic        out_valid,
  output out_item_t   out_item,
  output logic        pop
);
  logic [2:0] idx_r;
  logic       done;

  assign out_valid = have;
  assign done      = (idx_r == head.cnt_m1);
  assign pop       = have && !out_stall && done;

  always_comb begin
    out_item.push_target       = head.target;
    out_item.pixel_color       = head.colors[{idx_r, 1'b0} +: 2];
    out_item.palette_select    = head.pal;
    out_item.behind_background = head.beh;
    out_item.fifo_stopped      = head.stopped;
    out_item.last              = done;
  end

  // advance through the burst, one item per accepted cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (have && !out_stall) begin
      idx_r <= done ? 3'd0 : idx_r + 3'd1;
    end
  end
endmodule
`default_nettype wire
